### design/mkrh_pkg.sv
// Shared constants for the multi-key row hash: field widths, the murmur3
// finalizer multipliers and the hash-combine constant. No dependencies.
package mkrh_pkg;

   localparam int unsigned HASH_W      = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned POS_W       = 4;

   localparam logic [COUNT_W-1:0] KEY_COUNT_MAX   = 5'd16;
   localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = 5'd1;

   localparam logic [HASH_W-1:0] FMIX_MUL1   = 32'h85eb_ca6b;
   localparam logic [HASH_W-1:0] FMIX_MUL2   = 32'hc2b2_ae35;
   localparam logic [HASH_W-1:0] COMBINE_ADD = 32'h9e37_79b9;

   typedef logic [HASH_W-1:0] word_type;

   // a ^ (b + golden + (a << 6) + (a >> 2)), mod 2^32
   function automatic word_type combine32(input word_type a, input word_type b);
      word_type t;
      t = b + COMBINE_ADD + (a << 6) + (a >> 2);
      return a ^ t;
   endfunction

endpackage

### design/multi_key_row_hash.sv
// Top level of the multi-key row hash: sequencer, row state, output register.
// Depends on mkrh_pkg and mkrh_mul.
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  req     | req_valid/ready, key_value, key_null, row_selected | in
//  rsp     | rsp_valid/ready, row_hash, row_valid               | out
//  csr     | csr_valid/ready, csr_key_count                     | in
//
// A request whose row stays valid goes through accept, two passes through the
// one shared multiplier (the two finalizer multiplies), then the combine and
// update. A null or deselected key, or a key of a row already invalid, skips
// the multiplier. On the last key of a row the result waits in the output
// register; a new request is taken while it waits, but finishing the next
// row's last key stalls until the previous result is taken.
// Synchronous reset restores key_count to 1 and starts a fresh row.
module multi_key_row_hash (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_key_value,
   input  logic        req_key_null,
   input  logic        req_row_selected,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_row_hash,
   output logic        rsp_row_valid,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_key_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_FIN
   } state_type;

   state_type state_ff;

   // row state
   logic [mkrh_pkg::POS_W-1:0]   pos_ff;
   mkrh_pkg::word_type           running_ff;
   logic                         row_ok_ff;
   logic [mkrh_pkg::COUNT_W-1:0] key_count_ff;

   // per-request working registers
   mkrh_pkg::word_type mix_ff;
   logic               ok_ff;
   logic               last_ff;

   // output register
   logic               rsp_valid_ff;
   mkrh_pkg::word_type rsp_hash_ff;
   logic               rsp_ok_ff;

   logic [mkrh_pkg::COUNT_W-1:0] eff_count;
   logic [mkrh_pkg::COUNT_W-1:0] next_pos;
   logic                         ok_in;
   logic                         last_in;
   mkrh_pkg::word_type           key_word;
   mkrh_pkg::word_type           mix_in;

   mkrh_pkg::word_type mul_a;
   mkrh_pkg::word_type mul_b;
   mkrh_pkg::word_type product;
   logic               mul_enable;

   mkrh_pkg::word_type fmix_hash;
   mkrh_pkg::word_type running_in;
   logic               can_finish;
   logic               row_done;

   // --- accept side -------------------------------------------------------
   // Clamp the key count: zero counts as one, anything above sixteen saturates.
   always_comb begin
      if (key_count_ff == '0) begin
         eff_count = mkrh_pkg::COUNT_W'(1);
      end else if (key_count_ff > mkrh_pkg::KEY_COUNT_MAX) begin
         eff_count = mkrh_pkg::KEY_COUNT_MAX;
      end else begin
         eff_count = key_count_ff;
      end
   end

   assign next_pos = {1'b0, pos_ff} + mkrh_pkg::COUNT_W'(1);
   assign last_in  = next_pos >= eff_count;
   assign ok_in    = row_ok_ff & ~req_key_null & req_row_selected;
   assign key_word = mkrh_pkg::word_type'(req_key_value);
   assign mix_in   = key_word ^ (key_word >> 16);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // --- shared multiplier -------------------------------------------------
   assign mul_enable = (state_ff == S_MUL1) || (state_ff == S_MUL2);

   always_comb begin
      if (state_ff == S_MUL2) begin
         mul_a = product ^ (product >> 13);
         mul_b = mkrh_pkg::FMIX_MUL2;
      end else begin
         mul_a = mix_ff;
         mul_b = mkrh_pkg::FMIX_MUL1;
      end
   end

   mkrh_mul u_mul (
      .clock     (clock),
      .enable    (mul_enable),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   // --- finish step -------------------------------------------------------
   assign fmix_hash  = product ^ (product >> 16);
   assign running_in = (pos_ff == '0) ? fmix_hash
                                      : mkrh_pkg::combine32(running_ff, fmix_hash);

   // hold the last key of a row until the output register is free
   assign can_finish = !last_ff || !rsp_valid_ff || rsp_ready;
   assign row_done   = (state_ff == S_FIN) && can_finish && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         running_ff   <= '0;
         row_ok_ff    <= 1'b1;
         key_count_ff <= mkrh_pkg::KEY_COUNT_RESET;
         mix_ff       <= '0;
         ok_ff        <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hash_ff  <= '0;
         rsp_ok_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            key_count_ff <= csr_key_count;
         end

         // raise the result when a row closes, drop it once taken
         if (row_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mix_ff   <= mix_in;
                  ok_ff    <= ok_in;
                  last_ff  <= last_in;
                  // skip the multiplies for a null or deselected key, or a row already invalid
                  state_ff <= ok_in ? S_MUL1 : S_FIN;
               end
            end
            S_MUL1: begin
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (can_finish) begin
                  if (last_ff) begin
                     rsp_hash_ff  <= ok_ff ? running_in : '0;
                     rsp_ok_ff    <= ok_ff;
                     pos_ff       <= '0;
                     running_ff   <= '0;
                     row_ok_ff    <= 1'b1;
                  end else begin
                     pos_ff    <= next_pos[mkrh_pkg::POS_W-1:0];
                     row_ok_ff <= ok_ff;
                     if (ok_ff) begin
                        running_ff <= running_in;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_hash  = rsp_hash_ff;
   assign rsp_row_valid = rsp_ok_ff;

endmodule

### design/mkrh_mul.sv
// Shared 32x32 multiplier keeping the low 32 bits, product registered.
// Depends on mkrh_pkg.
module mkrh_mul (
   input  logic              clock,
   input  logic              enable,
   input  mkrh_pkg::word_type operand_a,
   input  mkrh_pkg::word_type operand_b,
   output mkrh_pkg::word_type product
);

   mkrh_pkg::word_type product_ff;
   mkrh_pkg::word_type product_in;

   // only the low word of the product is kept
   assign product_in = operand_a * operand_b;

   // hold the product while the sequencer is not multiplying
   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

### tb/tb.sv
// Self-checking testbench for the multi-key row hash (multi_key_row_hash).
// Depends on mkrh_pkg for widths and hash constants, and on the RTL of the block.
// A local row-hash predictor is checked against every response, field by field.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Let a request that ends no row finish inside the block before touching the register.
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      mkrh_pkg::word_type hash;
      logic               ok;
   } row_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic signed [31:0]  req_key_value = '0;
   logic                req_key_null = 1'b0;
   logic                req_row_selected = 1'b1;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [31:0]         rsp_row_hash;
   logic                rsp_row_valid;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [mkrh_pkg::COUNT_W-1:0] csr_key_count = mkrh_pkg::KEY_COUNT_RESET;

   // Predictor state: the row being built, and its view of the key_count register.
   logic [mkrh_pkg::COUNT_W-1:0] key_count_cfg = mkrh_pkg::KEY_COUNT_RESET;
   logic [mkrh_pkg::POS_W-1:0]   key_pos = '0;
   mkrh_pkg::word_type           row_acc = '0;
   logic                         row_good = 1'b1;

   // Row results still owed by the block, oldest first.
   row_result_type      row_results_due[$];
   int                  mismatch_count = 0;

   // Idling controls, shared by the test sequence and the response side.
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   int                  rsp_hold_len = 0;

   multi_key_row_hash i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_value    (req_key_value),
      .req_key_null     (req_key_null),
      .req_row_selected (req_row_selected),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_hash     (rsp_row_hash),
      .rsp_row_valid    (rsp_row_valid),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_key_count    (csr_key_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Clamp a register value to the key count the block actually uses.
   function automatic logic [mkrh_pkg::COUNT_W-1:0] keys_per_row(
         input logic [mkrh_pkg::COUNT_W-1:0] v);
      if (v == '0) return 5'd1;
      if (v > mkrh_pkg::KEY_COUNT_MAX) return mkrh_pkg::KEY_COUNT_MAX;
      return v;
   endfunction

   // 32-bit avalanche finaliser applied to each key of a still-valid row before it joins the row.
   function automatic mkrh_pkg::word_type finalize_key(input mkrh_pkg::word_type k);
      mkrh_pkg::word_type h;
      h = k ^ {16'h0, k[31:16]};
      h = h * mkrh_pkg::FMIX_MUL1;
      h = h ^ {13'h0, h[31:13]};
      h = h * mkrh_pkg::FMIX_MUL2;
      h = h ^ {16'h0, h[31:16]};
      return h;
   endfunction

   // Advance the row state by one request; return 1 when it closes a row.
   function automatic bit predict_row(input mkrh_pkg::word_type value, input logic is_null,
                                      input logic selected, output row_result_type res);
      logic [mkrh_pkg::COUNT_W-1:0] eff;
      mkrh_pkg::word_type           kh;
      mkrh_pkg::word_type           sum;
      eff = keys_per_row(key_count_cfg);
      if (is_null || !selected) row_good = 1'b0;
      // Once the row is spoilt, later keys are not hashed at all.
      if (row_good) begin
         kh = finalize_key(value);
         if (key_pos == '0) begin
            row_acc = kh;
         end else begin
            sum = kh + mkrh_pkg::COMBINE_ADD + {row_acc[25:0], 6'b0}
                  + {2'b0, row_acc[31:2]};
            row_acc = row_acc ^ sum;
         end
      end
      // The row closes on the first key whose position reaches the current count,
      // even if the count was lowered part way through the row.
      if (({1'b0, key_pos} + 5'd1) < eff) begin
         key_pos = key_pos + 1'b1;
         return 1'b0;
      end
      res.hash = row_good ? row_acc : '0;
      res.ok   = row_good;
      key_pos  = '0;
      row_acc  = '0;
      row_good = 1'b1;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Request side and register writes (all entered at a falling edge)
   // ------------------------------------------------------------------

   // Offer one key request, hold it until taken, then predict its effect.
   task automatic send_key(input mkrh_pkg::word_type value, input logic is_null,
                           input logic selected);
      row_result_type res;
      // Drop valid for a random burst now and then; the gap starts on this edge.
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_key_value    <= value;
      req_key_null     <= is_null;
      req_row_selected <= selected;
      do @(posedge clock); while (!req_ready);
      if (predict_row(value, is_null, selected, res)) row_results_due.push_back(res);
      @(negedge clock);
   endtask

   // Withdraw the request, wait for every owed row, then let the block go quiet.
   task automatic wait_rows_done();
      req_valid <= 1'b0;
      while (row_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key_count(input logic [mkrh_pkg::COUNT_W-1:0] v);
      csr_valid     <= 1'b1;
      csr_key_count <= v;
      do @(posedge clock); while (!csr_ready);
      key_count_cfg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic mkrh_pkg::word_type pick_key();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Send one row; a broken row scatters nulls and deselected keys through it.
   task automatic send_row(input int n_keys, input bit broken);
      for (int i = 0; i < n_keys; i++) begin
         if (broken)
            send_key(pick_key(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
         else
            send_key(pick_key(), 1'b0, 1'b1);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Drive ready: a long hold when asked, random stall bursts otherwise.
   initial begin : rsp_drive
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
            rsp_ready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void note_mismatch(input string what, input row_result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected hash %08h valid %0b, got hash %08h valid %0b",
                  $realtime, what, want.hash, want.ok, rsp_row_hash, rsp_row_valid);
   endfunction

   // Compare each response taken with the oldest owed row.
   always @(posedge clock) begin : rsp_check
      row_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (row_results_due.size() == 0) begin
            want.hash = 'x;
            want.ok   = 1'bx;
            note_mismatch("response with no row pending", want);
         end else begin
            want = row_results_due.pop_front();
            if (rsp_row_hash !== want.hash)
               note_mismatch("row_hash differs", want);
            else if (rsp_row_valid !== want.ok)
               note_mismatch("row_valid differs", want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Single-key rows at the reset count: key extremes, null and deselected keys.
   task automatic test_key_extremes();
      send_key(32'h8000_0000, 1'b0, 1'b1);
      send_key(32'h7fff_ffff, 1'b0, 1'b1);
      send_key(32'h0000_0000, 1'b0, 1'b1);
      send_key(32'hffff_ffff, 1'b0, 1'b1);
      send_key(32'h1234_5678, 1'b1, 1'b1);
      send_key(32'h1234_5678, 1'b0, 1'b0);
      send_key(32'hdead_beef, 1'b1, 1'b0);
      wait_rows_done();
   endtask

   // A register value of zero behaves as one key per row.
   task automatic test_count_zero();
      write_key_count(5'd0);
      send_key(32'h0000_0001, 1'b0, 1'b1);
      send_key(32'hffff_fffe, 1'b0, 1'b1);
      wait_rows_done();
   endtask

   // Two-key rows: a null or a deselected key on either position spoils the row.
   task automatic test_row_invalidation();
      write_key_count(5'd2);
      send_key(32'h0000_0005, 1'b1, 1'b1);
      send_key(32'h0000_0006, 1'b0, 1'b1);
      send_key(32'h0000_0007, 1'b0, 1'b1);
      send_key(32'h0000_0008, 1'b0, 1'b0);
      send_key(32'h8000_0000, 1'b0, 1'b0);
      send_key(32'h7fff_ffff, 1'b0, 1'b1);
      send_key(32'hcafe_f00d, 1'b0, 1'b1);
      send_key(32'h0bad_cafe, 1'b0, 1'b1);
      wait_rows_done();
   endtask

   // Lower the count part way through a row: the next key closes it.
   task automatic test_count_change_mid_row();
      write_key_count(5'd4);
      send_key(32'h0000_0011, 1'b0, 1'b1);
      send_key(32'h0000_0022, 1'b0, 1'b1);
      wait_rows_done();
      write_key_count(5'd2);
      send_key(32'h0000_0033, 1'b0, 1'b1);
      wait_rows_done();
   endtask

   // Hold responses off for a long stretch while requests keep coming, so the
   // block fills and stalls its input; then pause until every row is back.
   task automatic test_output_backpressure();
      write_key_count(5'd1);
      req_idle_on  = 1'b0;
      rsp_hold_len = 200;
      for (int i = 0; i < 40; i++) send_key(pick_key(), 1'b0, 1'b1);
      wait_rows_done();
      req_idle_on = 1'b1;
   endtask

   // Random rows over several counts, extremes included; the last phase runs
   // with no idling on either side.
   task automatic test_random_rows();
      logic [mkrh_pkg::COUNT_W-1:0] counts[10];
      int                           eff;
      int                           rows;
      counts = '{5'd1, 5'd31, 5'd2, 5'd16, 5'd3, 5'd17, 5'd0, 5'd7, 5'd5, 5'd1};
      counts[9] = mkrh_pkg::COUNT_W'($urandom_range(0, 31));
      for (int p = 0; p < 10; p++) begin
         if (p == 9) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         write_key_count(counts[p]);
         eff  = int'(keys_per_row(counts[p]));
         rows = (200 + eff - 1) / eff;
         for (int r = 0; r < rows; r++) send_row(eff, $urandom_range(0, 9) < 3);
         // Leave a row open now and then so the next count takes over mid-row.
         if (eff > 1 && $urandom_range(0, 1) == 1)
            send_row($urandom_range(1, eff - 1), $urandom_range(0, 9) < 3);
         wait_rows_done();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin : run
      // Hold reset from the start, release it on a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_key_extremes();
      test_count_zero();
      test_row_invalidation();
      test_count_change_mid_row();
      test_output_backpressure();
      test_random_rows();

      // Every row is back; allow stray responses a chance to show up.
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && row_results_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
design/mkrh_pkg.sv
design/mkrh_mul.sv
design/multi_key_row_hash.sv
tb/tb.sv
